[hw/rtl/acbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbp_pkg
// Shared types, codes and constants of the ant-colony bin-packing engine.
// ----------------------------------------------------------------------------
package acbp_pkg;

  localparam int NODE_W     = 10;
  localparam int EBIN_W     = 5;
  localparam int PHER_W     = 32;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;
  localparam int NT_W       = 11;
  localparam int BT_W       = 5;
  localparam int RATE_W     = 16;
  localparam int SEED_W     = 16;
  localparam int ITEM_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVD_W     = 23;
  localparam int DCNT_W     = 5;

  localparam logic [DIVD_W-1:0] REINF_DIVIDEND = 23'h640000;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STEP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EVAP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REINF  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOPATH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WMODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_CHK, S_ST_CHK, S_ST_SUM, S_ST_MUL, S_ST_TGT,
    S_ST_SEL, S_ST_APPLY, S_SPREAD, S_EV_RD, S_EV_MUL, S_EV_WR, S_RF_DIV,
    S_RF_P0, S_RF_P1, S_RF_P2, S_RF_CNT, S_RF_E, S_RF_EW, S_RESP
  } state_e;

  function automatic logic [31:0] lfsr_taps(input int bits);
    logic [31:0] t;
    case (bits)
      8:       t = 32'hB8;
      9:       t = 32'h110;
      10:      t = 32'h240;
      11:      t = 32'h500;
      12:      t = 32'h829;
      13:      t = 32'h100D;
      14:      t = 32'h2015;
      15:      t = 32'h6000;
      16:      t = 32'hD008;
      17:      t = 32'h12000;
      18:      t = 32'h20400;
      19:      t = 32'h40023;
      20:      t = 32'h90000;
      21:      t = 32'h140000;
      22:      t = 32'h300000;
      23:      t = 32'h420000;
      24:      t = 32'hE10000;
      25:      t = 32'h1200000;
      26:      t = 32'h2000023;
      27:      t = 32'h4000013;
      28:      t = 32'h9000000;
      29:      t = 32'h14000000;
      30:      t = 32'h20000029;
      31:      t = 32'h48000000;
      32:      t = 32'h80200003;
      default: t = 32'hB8;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/acbp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module acbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hw/rtl/ant_colony_bin_packing_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ant_colony_bin_packing_engine
// Ant-colony bin packer: edge lists, roulette walk, evaporation, reinforcement.
// ----------------------------------------------------------------------------
// Steps: in the final layer the first edge is taken, elsewhere a roulette over
//   the node's edges; at the end node the bin spread is computed. Evaporation
//   sweeps all edges; reinforcement walks the path and each visited edge list.
// Requests are handled one at a time; busy stays high through the result strobe.
// Reset: the edge count of every node is swept to zero in S_CLEAR, busy high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall.
module ant_colony_bin_packing_engine #(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_BINS    = 16,
  parameter int MAX_PATH    = 1024,
  parameter int RANDOM_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [acbp_pkg::REQ_W-1:0]          req_type_i,
  input  wire logic [acbp_pkg::NODE_W-1:0]         source_node_i,
  input  wire logic [acbp_pkg::NODE_W-1:0]         target_node_i,
  input  wire logic [acbp_pkg::EBIN_W-1:0]         edge_bin_number_i,
  input  wire logic [acbp_pkg::PHER_W-1:0]         initial_pheromone_i,
  input  wire logic [31:0]                         path_fitness_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [acbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [acbp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                     done_o,
  output logic      [acbp_pkg::NODE_W-1:0]         visited_node_o,
  output logic                                     path_finished_o,
  output logic      [31:0]                         bin_spread_o,
  output logic      [acbp_pkg::STAT_W-1:0]         status_o
);

  localparam int NW     = acbp_pkg::NODE_W;
  localparam int BW     = acbp_pkg::EBIN_W;
  localparam int PW     = acbp_pkg::PHER_W;
  localparam int RB     = RANDOM_BITS;
  localparam int EDEPTH = MAX_NODES * MAX_BINS;
  localparam int EA_W   = $clog2(EDEPTH);
  localparam int NA_W   = $clog2(MAX_NODES);
  localparam int PA_W   = $clog2(MAX_PATH);
  localparam int PL_W   = $clog2(MAX_PATH + 1);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int BI_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SUM_W  = PW + CNT_W;
  localparam int LO_W   = 32 + RB;
  localparam int HI_W   = SUM_W - 32 + RB;
  localparam int PR_W   = SUM_W + RB;
  localparam int EW     = NW + BW + PW;
  localparam int NT_W   = acbp_pkg::NT_W;
  localparam int BT_W   = acbp_pkg::BT_W;
  localparam int DIVD_W = acbp_pkg::DIVD_W;
  localparam int DCNT_W = acbp_pkg::DCNT_W;

  function automatic logic [EA_W-1:0] edge_addr(input logic [NW-1:0] n,
                                                input logic [CNT_W-1:0] j);
    return EA_W'(32'(n) * MAX_BINS + 32'(j));
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [RB-1:0] seed_value(input logic [acbp_pkg::SEED_W-1:0] s);
    logic [RB-1:0] m;
    m = RB'(s);
    return (m == '0) ? RB'(1) : m;
  endfunction

  acbp_pkg::state_e state_q, state_d;

  logic [NT_W-1:0]              node_total_q;
  logic [BT_W-1:0]              bin_total_q;
  logic                         wmode_q;
  logic [acbp_pkg::RATE_W-1:0]  rate_q;
  logic [acbp_pkg::SEED_W-1:0]  seed_q;
  logic [RB-1:0]                lfsr_q;

  logic [NW-1:0]                src_q, dst_q;
  logic [BW-1:0]                ebin_q;
  logic [PW-1:0]                pher_in_q;
  logic [NW-1:0]                vis_q;
  logic                         fin_q;
  logic [31:0]                  spr_q;
  logic [acbp_pkg::STAT_W-1:0]  stat_q;

  logic [CNT_W-1:0]             cnt_q, j_q, sp_q;
  logic [SUM_W-1:0]             sum_q, target_q;
  logic [LO_W-1:0]              lo_q;
  logic [HI_W-1:0]              hi_q;
  logic                         found_q;
  logic [BW-1:0]                sel_bin_q;
  logic [NW-1:0]                sel_dest_q;
  logic [31:0]                  bw_q [MAX_BINS];
  logic [PL_W-1:0]              path_len_q;
  logic [NW-1:0]                cur_node_q;
  logic [acbp_pkg::ITEM_W-1:0]  item_q;
  logic                         walk_q;
  logic [31:0]                  mx_q, mn_q;
  logic [EA_W-1:0]              k_q;
  logic [31:0]                  ev_q;
  logic [NA_W-1:0]              clr_q;
  logic [31:0]                  rem_q, fit_q, add_q;
  logic [DIVD_W-1:0]            quo_q, dvd_q;
  logic [DCNT_W-1:0]            dcnt_q;
  logic [PL_W-1:0]              rf_i_q;
  logic [NW-1:0]                rf_s_q, rf_nx_q;

  logic            cnt_we;
  logic [NA_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic            edge_we;
  logic [EA_W-1:0] edge_waddr, edge_raddr;
  logic [EW-1:0]   edge_wdata, edge_rdata;
  logic            path_we;
  logic [PA_W-1:0] path_waddr, path_raddr;
  logic [NW-1:0]   path_wdata, path_rdata;

  acbp_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_count_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  acbp_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  acbp_ram #(.WIDTH(NW), .DEPTH(MAX_PATH)) u_path_ram (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

  logic [NW-1:0]   e_dest;
  logic [BW-1:0]   e_bin;
  logic [PW-1:0]   e_pher;
  assign e_dest = edge_rdata[EW-1 -: NW];
  assign e_bin  = edge_rdata[PW +: BW];
  assign e_pher = edge_rdata[PW-1:0];

  logic [NT_W-1:0] eff_nodes, end_node, fstart;
  logic [BT_W-1:0] eff_bins;
  logic            accept, load_bad, cur_is_end, cur_in_final, path_full;
  logic            clr_last, div_last, k_last, rf_stop, rf_more, sp_done, j_done;
  logic [SUM_W-1:0] rs;
  logic [PR_W-1:0] prod;
  logic [47:0]     evp;
  logic [32:0]     div_r;
  logic            div_ge;
  logic [NT_W-1:0] w1;
  logic [21:0]     wgt;
  logic            bin_ok;
  logic [BI_W-1:0] bin_idx;
  logic [RB-1:0]   lfsr_nx;

  always_comb begin
    if (node_total_q < NT_W'(3)) begin
      eff_nodes = NT_W'(3);
    end else if (32'(node_total_q) > MAX_NODES) begin
      eff_nodes = NT_W'(MAX_NODES);
    end else begin
      eff_nodes = node_total_q;
    end
    if (bin_total_q == '0) begin
      eff_bins = BT_W'(1);
    end else if (32'(bin_total_q) > MAX_BINS) begin
      eff_bins = BT_W'(MAX_BINS);
    end else begin
      eff_bins = bin_total_q;
    end
  end

  assign end_node     = eff_nodes - NT_W'(1);
  assign fstart       = (end_node > NT_W'(eff_bins)) ? end_node - NT_W'(eff_bins) : '0;
  assign accept       = start_i && !busy_o;
  assign load_bad     = (32'(source_node_i) >= MAX_NODES) || (32'(target_node_i) >= MAX_NODES)
                        || (edge_bin_number_i == '0) || (32'(edge_bin_number_i) > MAX_BINS);
  assign cur_is_end   = NT_W'(cur_node_q) == end_node;
  assign cur_in_final = NT_W'(cur_node_q) >= fstart;
  assign path_full    = 32'(path_len_q) >= MAX_PATH;
  assign clr_last     = clr_q == NA_W'(MAX_NODES - 1);
  assign div_last     = dcnt_q == DCNT_W'(DIVD_W - 1);
  assign k_last       = k_q == EA_W'(EDEPTH - 1);
  assign rf_stop      = (NT_W'(rf_s_q) == end_node) || (32'(rf_s_q) >= MAX_NODES);
  assign rf_more      = (32'(rf_i_q) + 32'd2) < 32'(path_len_q);
  assign sp_done      = 32'(sp_q) >= 32'(eff_bins);
  assign j_done       = j_q == cnt_q;
  assign rs           = sum_q + SUM_W'(e_pher);
  assign prod         = {hi_q, 32'b0} + PR_W'(lo_q);
  assign evp          = 48'(e_pher) * 48'(rate_q);
  assign div_r        = {rem_q, dvd_q[DIVD_W-1]};
  assign div_ge       = div_r >= {1'b0, fit_q};
  assign w1           = NT_W'(item_q) + NT_W'(1);
  assign wgt          = wmode_q ? 22'(w1) : 22'(w1) * 22'(w1);
  assign bin_ok       = (sel_bin_q != '0) && (BT_W'(sel_bin_q) <= eff_bins);
  assign bin_idx      = BI_W'(sel_bin_q - BW'(1));
  assign lfsr_nx      = (lfsr_q >> 1) ^ (lfsr_q[0] ? RB'(acbp_pkg::lfsr_taps(RB)) : '0);
  assign cfg_ready_o  = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      acbp_pkg::S_CLEAR: begin
        if (clr_last) state_d = acbp_pkg::S_IDLE;
      end
      acbp_pkg::S_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            acbp_pkg::REQ_LOAD: begin
              state_d = load_bad ? acbp_pkg::S_RESP : acbp_pkg::S_LD_CHK;
            end
            acbp_pkg::REQ_STEP: begin
              if (!walk_q) state_d = acbp_pkg::S_RESP;
              else if (cur_is_end) state_d = acbp_pkg::S_SPREAD;
              else state_d = acbp_pkg::S_ST_CHK;
            end
            acbp_pkg::REQ_EVAP:  state_d = acbp_pkg::S_EV_RD;
            acbp_pkg::REQ_REINF: begin
              state_d = (path_len_q == '0) ? acbp_pkg::S_RESP : acbp_pkg::S_RF_DIV;
            end
            default: state_d = acbp_pkg::S_RESP;
          endcase
        end
      end
      acbp_pkg::S_LD_CHK: state_d = acbp_pkg::S_RESP;
      acbp_pkg::S_ST_CHK: begin
        if (cnt_rdata == '0 || path_full) state_d = acbp_pkg::S_RESP;
        else if (cur_in_final) state_d = acbp_pkg::S_ST_SEL;
        else state_d = acbp_pkg::S_ST_SUM;
      end
      acbp_pkg::S_ST_SUM: begin
        if (j_done) state_d = acbp_pkg::S_ST_MUL;
      end
      acbp_pkg::S_ST_MUL: state_d = acbp_pkg::S_ST_TGT;
      acbp_pkg::S_ST_TGT: state_d = acbp_pkg::S_ST_SEL;
      acbp_pkg::S_ST_SEL: begin
        if (j_done) state_d = acbp_pkg::S_ST_APPLY;
      end
      acbp_pkg::S_ST_APPLY: state_d = acbp_pkg::S_RESP;
      acbp_pkg::S_SPREAD: begin
        if (sp_done) state_d = acbp_pkg::S_RESP;
      end
      acbp_pkg::S_EV_RD:  state_d = acbp_pkg::S_EV_MUL;
      acbp_pkg::S_EV_MUL: state_d = acbp_pkg::S_EV_WR;
      acbp_pkg::S_EV_WR:  state_d = k_last ? acbp_pkg::S_RESP : acbp_pkg::S_EV_RD;
      acbp_pkg::S_RF_DIV: begin
        if (div_last) begin
          state_d = (path_len_q > PL_W'(1)) ? acbp_pkg::S_RF_P0 : acbp_pkg::S_RESP;
        end
      end
      acbp_pkg::S_RF_P0:  state_d = acbp_pkg::S_RF_P1;
      acbp_pkg::S_RF_P1:  state_d = acbp_pkg::S_RF_P2;
      acbp_pkg::S_RF_P2:  state_d = rf_stop ? acbp_pkg::S_RESP : acbp_pkg::S_RF_CNT;
      acbp_pkg::S_RF_CNT: state_d = acbp_pkg::S_RF_E;
      acbp_pkg::S_RF_E: begin
        if (j_done) state_d = rf_more ? acbp_pkg::S_RF_P0 : acbp_pkg::S_RESP;
        else state_d = acbp_pkg::S_RF_EW;
      end
      acbp_pkg::S_RF_EW:  state_d = acbp_pkg::S_RF_E;
      acbp_pkg::S_RESP:   state_d = acbp_pkg::S_IDLE;
      default:            state_d = acbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy_o     = state_q != acbp_pkg::S_IDLE;
    done_o     = state_q == acbp_pkg::S_RESP;
    cnt_we     = 1'b0;
    cnt_waddr  = NA_W'(src_q);
    cnt_wdata  = cnt_rdata + CNT_W'(1);
    cnt_raddr  = (req_type_i == acbp_pkg::REQ_STEP) ? NA_W'(cur_node_q) : NA_W'(source_node_i);
    edge_we    = 1'b0;
    edge_waddr = edge_addr(src_q, cnt_rdata);
    edge_wdata = {dst_q, ebin_q, pher_in_q};
    edge_raddr = edge_addr(cur_node_q, j_q);
    path_we    = 1'b0;
    path_waddr = PA_W'(path_len_q);
    path_wdata = cur_node_q;
    path_raddr = PA_W'(rf_i_q);
    case (state_q)
      acbp_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
      end
      acbp_pkg::S_IDLE: begin
        path_we = accept && (req_type_i == acbp_pkg::REQ_STEP) && walk_q && cur_is_end
                  && !path_full;
      end
      acbp_pkg::S_LD_CHK: begin
        cnt_we  = 32'(cnt_rdata) < MAX_BINS;
        edge_we = 32'(cnt_rdata) < MAX_BINS;
      end
      acbp_pkg::S_ST_APPLY: path_we = 1'b1;
      acbp_pkg::S_EV_RD, acbp_pkg::S_EV_MUL: edge_raddr = k_q;
      acbp_pkg::S_EV_WR: begin
        edge_raddr = k_q;
        edge_we    = 1'b1;
        edge_waddr = k_q;
        edge_wdata = {e_dest, e_bin, ev_q};
      end
      acbp_pkg::S_RF_P1, acbp_pkg::S_RF_P2: begin
        path_raddr = PA_W'(rf_i_q + PL_W'(1));
        cnt_raddr  = NA_W'(rf_s_q);
      end
      acbp_pkg::S_RF_E: edge_raddr = edge_addr(rf_s_q, j_q);
      acbp_pkg::S_RF_EW: begin
        edge_raddr = edge_addr(rf_s_q, j_q);
        edge_we    = e_dest == rf_nx_q;
        edge_waddr = edge_addr(rf_s_q, j_q);
        edge_wdata = {e_dest, e_bin, sat_add(e_pher, add_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acbp_pkg::S_CLEAR;
      node_total_q <= NT_W'(1024);
      bin_total_q  <= BT_W'(16);
      wmode_q      <= 1'b1;
      rate_q       <= 16'd58982;
      seed_q       <= 16'd1;
      lfsr_q       <= RB'(1);
      clr_q        <= '0;
      path_len_q   <= '0;
      cur_node_q   <= '0;
      item_q       <= '0;
      walk_q       <= 1'b0;
      for (int b = 0; b < MAX_BINS; b++) bw_q[b] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          acbp_pkg::CFG_NODES: node_total_q <= cfg_data_i[NT_W-1:0];
          acbp_pkg::CFG_BINS:  bin_total_q  <= cfg_data_i[BT_W-1:0];
          acbp_pkg::CFG_WMODE: wmode_q      <= cfg_data_i[0];
          acbp_pkg::CFG_RATE:  rate_q       <= cfg_data_i;
          acbp_pkg::CFG_SEED: begin
            seed_q <= cfg_data_i;
            lfsr_q <= seed_value(cfg_data_i);
          end
          default: ;
        endcase
      end
      case (state_q)
        acbp_pkg::S_CLEAR: clr_q <= clr_q + NA_W'(1);
        acbp_pkg::S_IDLE: begin
          if (start_i) begin
            src_q     <= source_node_i;
            dst_q     <= target_node_i;
            ebin_q    <= edge_bin_number_i;
            pher_in_q <= initial_pheromone_i;
            vis_q     <= '0;
            fin_q     <= 1'b0;
            spr_q     <= '0;
            stat_q    <= acbp_pkg::ST_OK;
            k_q       <= '0;
            rem_q     <= '0;
            quo_q     <= '0;
            dvd_q     <= acbp_pkg::REINF_DIVIDEND;
            dcnt_q    <= '0;
            fit_q     <= path_fitness_i;
            rf_i_q    <= '0;
            mx_q      <= bw_q[0];
            mn_q      <= bw_q[0];
            sp_q      <= CNT_W'(1);
            case (req_type_i)
              acbp_pkg::REQ_LOAD: begin
                if (load_bad) stat_q <= acbp_pkg::ST_REJECT;
              end
              acbp_pkg::REQ_START: begin
                for (int b = 0; b < MAX_BINS; b++) bw_q[b] <= '0;
                path_len_q <= '0;
                cur_node_q <= '0;
                item_q     <= '0;
                walk_q     <= 1'b1;
              end
              acbp_pkg::REQ_STEP: begin
                if (!walk_q) begin
                  stat_q <= acbp_pkg::ST_NOPATH;
                end else if (cur_is_end) begin
                  if (!path_full) path_len_q <= path_len_q + PL_W'(1);
                  walk_q <= 1'b0;
                  vis_q  <= cur_node_q;
                  fin_q  <= 1'b1;
                end
              end
              acbp_pkg::REQ_REINF: begin
                if (path_len_q == '0) stat_q <= acbp_pkg::ST_NOPATH;
              end
              default: ;
            endcase
          end
        end
        acbp_pkg::S_LD_CHK: begin
          if (32'(cnt_rdata) >= MAX_BINS) stat_q <= acbp_pkg::ST_REJECT;
        end
        acbp_pkg::S_ST_CHK: begin
          j_q     <= '0;
          sum_q   <= '0;
          found_q <= 1'b0;
          if (cnt_rdata == '0 || path_full) begin
            walk_q <= 1'b0;
            stat_q <= acbp_pkg::ST_NOPATH;
          end else if (cur_in_final) begin
            cnt_q    <= CNT_W'(1);
            target_q <= '0;
          end else begin
            cnt_q  <= cnt_rdata;
            lfsr_q <= lfsr_nx;
          end
        end
        acbp_pkg::S_ST_SUM: begin
          if (j_q != '0) sum_q <= rs;
          if (!j_done) j_q <= j_q + CNT_W'(1);
        end
        acbp_pkg::S_ST_MUL: begin
          lo_q <= LO_W'(sum_q[31:0]) * LO_W'(lfsr_q);
          hi_q <= HI_W'(sum_q[SUM_W-1:32]) * HI_W'(lfsr_q);
        end
        acbp_pkg::S_ST_TGT: begin
          target_q <= prod[PR_W-1:RB];
          j_q      <= '0;
          sum_q    <= '0;
          found_q  <= 1'b0;
        end
        acbp_pkg::S_ST_SEL: begin
          if (j_q != '0) begin
            sum_q <= rs;
            if (!found_q && (rs >= target_q || j_done)) begin
              found_q    <= 1'b1;
              sel_bin_q  <= e_bin;
              sel_dest_q <= e_dest;
            end
          end
          if (!j_done) j_q <= j_q + CNT_W'(1);
        end
        acbp_pkg::S_ST_APPLY: begin
          if (bin_ok) bw_q[bin_idx] <= sat_add(bw_q[bin_idx], 32'(wgt));
          path_len_q <= path_len_q + PL_W'(1);
          cur_node_q <= sel_dest_q;
          item_q     <= item_q + acbp_pkg::ITEM_W'(1);
          vis_q      <= cur_node_q;
        end
        acbp_pkg::S_SPREAD: begin
          if (sp_done) begin
            spr_q <= mx_q - mn_q;
          end else begin
            if (bw_q[sp_q[BI_W-1:0]] > mx_q) mx_q <= bw_q[sp_q[BI_W-1:0]];
            if (bw_q[sp_q[BI_W-1:0]] < mn_q) mn_q <= bw_q[sp_q[BI_W-1:0]];
            sp_q <= sp_q + CNT_W'(1);
          end
        end
        acbp_pkg::S_EV_MUL: ev_q <= evp[47:16];
        acbp_pkg::S_EV_WR:  k_q  <= k_q + EA_W'(1);
        acbp_pkg::S_RF_DIV: begin
          rem_q  <= div_ge ? 32'(div_r - {1'b0, fit_q}) : div_r[31:0];
          quo_q  <= {quo_q[DIVD_W-2:0], div_ge};
          dvd_q  <= dvd_q << 1;
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (div_last) begin
            add_q <= (fit_q == '0) ? 32'hFFFF_FFFF : 32'({quo_q[DIVD_W-2:0], div_ge});
          end
        end
        acbp_pkg::S_RF_P1:  rf_s_q  <= path_rdata;
        acbp_pkg::S_RF_P2:  rf_nx_q <= path_rdata;
        acbp_pkg::S_RF_CNT: begin
          cnt_q <= cnt_rdata;
          j_q   <= '0;
        end
        acbp_pkg::S_RF_E: begin
          if (j_done) rf_i_q <= rf_i_q + PL_W'(1);
        end
        acbp_pkg::S_RF_EW: j_q <= j_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign visited_node_o  = vis_q;
  assign path_finished_o = fin_q;
  assign bin_spread_o    = spr_q;
  assign status_o        = stat_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item did not raise busy");

  a_finish_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && path_finished_o) |-> (status_o == acbp_pkg::ST_OK && walk_q == 1'b0))
    else $error("finished path with bad status or live walk");

  a_reject_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == acbp_pkg::ST_REJECT) |->
      ($past(state_q) == acbp_pkg::S_LD_CHK || $past(state_q) == acbp_pkg::S_IDLE))
    else $error("reject status outside edge load");

endmodule
`default_nettype wire
